@@ rtl/graph_reachability_query_top_macros.svh @@
// ----------------------------------------------------------------------------
// Graph reachability query assertion macros
// Shared macros for concurrent assertions on the graph reachability block.
// ----------------------------------------------------------------------------
`ifndef GRAPH_REACHABILITY_QUERY_TOP_MACROS_SVH
`define GRAPH_REACHABILITY_QUERY_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GRQ_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("graph reachability assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GRQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("graph reachability assertion failed");

`endif

@@ rtl/gr_pkg.sv @@
// ----------------------------------------------------------------------------
// Graph reachability package
// Types and constants shared by the graph reachability block.
// ----------------------------------------------------------------------------
package gr_pkg;

  localparam int NODE_COUNT = 32;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int FIELD_W    = 5;
  localparam int KIND_W     = 2;

  typedef logic [NODE_W-1:0]     node_t;
  typedef logic [NODE_COUNT-1:0] row_t;
  typedef logic [FIELD_W-1:0]    field_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD   = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESULT
  } state_e;

  // Write command to the adjacency store.
  typedef struct packed {
    logic  add;
    logic  clr;
    node_t row;
    node_t col;
  } adj_cmd_t;

  // Status of the breadth search engine.
  typedef struct packed {
    logic done;
    logic hit;
  } bfs_status_t;

  // True when a node field names an existing node.
  function automatic logic node_in_range(field_t n);
    return ({1'b0, n} < (FIELD_W + 1)'(NODE_COUNT));
  endfunction

endpackage

@@ rtl/gr_if.sv @@
// ----------------------------------------------------------------------------
// Graph reachability channel interfaces
// Valid/ready channels for request and response transactions.
// ----------------------------------------------------------------------------
interface gr_req_if;
  import gr_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [FIELD_W-1:0]  source_node;
  logic [FIELD_W-1:0]  target_node;

  modport source (output valid, kind, source_node, target_node, input ready);
  modport sink   (input valid, kind, source_node, target_node, output ready);
endinterface

interface gr_rsp_if;
  logic valid;
  logic ready;
  logic connected;

  modport source (output valid, connected, input ready);
  modport sink   (input valid, connected, output ready);
endinterface

@@ rtl/gr_adj_store.sv @@
// ----------------------------------------------------------------------------
// Adjacency store
// One row of outgoing edges per node, with a valid bit per row so that a
// clear empties every row at once.
// ----------------------------------------------------------------------------
module gr_adj_store (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gr_pkg::adj_cmd_t cmd_i,
  input  gr_pkg::node_t    rd_addr_i,
  output gr_pkg::row_t     rd_data_o
);
  import gr_pkg::*;

  row_t rows_q [NODE_COUNT];
  row_t row_valid_q;
  row_t wr_row;

  always_comb begin
    wr_row = row_valid_q[cmd_i.row] ? rows_q[cmd_i.row] : '0;
    wr_row[cmd_i.col] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
    end else if (cmd_i.clr) begin
      row_valid_q <= '0;
    end else if (cmd_i.add) begin
      row_valid_q[cmd_i.row] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add && !cmd_i.clr) begin
      rows_q[cmd_i.row] <= wr_row;
    end
  end

  assign rd_data_o = row_valid_q[rd_addr_i] ? rows_q[rd_addr_i] : '0;

endmodule

@@ rtl/gr_bfs.sv @@
// ----------------------------------------------------------------------------
// Breadth search engine
// Holds the reached set and, while step_i is high, expands one pending node
// per cycle by merging its adjacency row into the reached set.
// ----------------------------------------------------------------------------
module gr_bfs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                step_i,
  input  gr_pkg::node_t       src_i,
  input  gr_pkg::node_t       dst_i,
  output gr_pkg::node_t       row_addr_o,
  input  gr_pkg::row_t        row_data_i,
  output gr_pkg::bfs_status_t status_o
);
  import gr_pkg::*;

  row_t  visited_q, visited_d;
  row_t  expanded_q, expanded_d;
  node_t dst_q;
  row_t  pending;
  row_t  lowest;
  node_t pick;

  always_comb begin
    pending = visited_q & ~expanded_q;
    lowest  = pending & (~pending + row_t'(1));
    pick    = '0;
    for (int i = 0; i < NODE_COUNT; i++) begin
      if (lowest[i]) begin
        pick = pick | node_t'(i);
      end
    end
  end

  assign status_o.hit  = visited_q[dst_q];
  assign status_o.done = visited_q[dst_q] || (pending == '0);
  assign row_addr_o    = pick;

  always_comb begin
    visited_d  = visited_q;
    expanded_d = expanded_q;
    if (start_i) begin
      visited_d        = '0;
      visited_d[src_i] = 1'b1;
      expanded_d       = '0;
    end else if (step_i && !status_o.done) begin
      visited_d  = visited_q | row_data_i;
      expanded_d = expanded_q | lowest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q  <= '0;
      expanded_q <= '0;
    end else begin
      visited_q  <= visited_d;
      expanded_q <= expanded_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dst_q <= dst_i;
    end
  end

endmodule

@@ rtl/graph_reachability_query_top.sv @@
// ----------------------------------------------------------------------------
// Graph reachability query top level
// Keeps a directed graph of up to 32 nodes and answers reachability queries.
// ----------------------------------------------------------------------------
// Requests arrive on req_i as transactions carrying a kind, a source node and
// a target node. An add transaction sets one edge and a clear transaction
// removes all edges; both finish in the accepting cycle and give no response.
// A query transaction gives one response on rsp_o with the connected flag.
// A query expands one reached node per cycle through the adjacency store
// read port until the target is reached or no node is pending, and req_i is
// not ready until the response is loaded. A query naming a node outside the
// graph skips the search and answers 0.
// The response sits in an output register. If the receiver stalls, an add or
// clear is still taken, but a finished query waits until the register frees.
// Reset empties the graph and drops any pending response.
// ----------------------------------------------------------------------------
module graph_reachability_query_top (
  input  logic   clk_i,
  input  logic   rst_ni,
  gr_req_if.sink   req_i,
  gr_rsp_if.source rsp_o
);
  import gr_pkg::*;

  state_e      state_q, state_d;
  logic        res_q, res_d;
  logic        out_valid_q, out_valid_d;
  logic        out_data_q, out_data_d;
  adj_cmd_t    cmd;
  logic        start;
  logic        step;
  node_t       row_addr;
  row_t        row_data;
  bfs_status_t status;
  logic        req_fire;
  logic        in_range;

  assign req_fire = req_i.valid && req_i.ready;
  assign in_range = node_in_range(req_i.source_node) && node_in_range(req_i.target_node);

  gr_adj_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .rd_addr_i (row_addr),
    .rd_data_o (row_data)
  );

  gr_bfs u_bfs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .step_i     (step),
    .src_i      (node_t'(req_i.source_node)),
    .dst_i      (node_t'(req_i.target_node)),
    .row_addr_o (row_addr),
    .row_data_i (row_data),
    .status_o   (status)
  );

  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_data_d  = out_data_q;
    cmd         = '0;
    cmd.row     = node_t'(req_i.source_node);
    cmd.col     = node_t'(req_i.target_node);
    start       = 1'b0;
    step        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          case (req_i.kind)
            KIND_ADD: begin
              cmd.add = in_range;
            end
            KIND_CLEAR: begin
              cmd.clr = 1'b1;
            end
            KIND_QUERY: begin
              if (in_range) begin
                start   = 1'b1;
                state_d = ST_SEARCH;
              end else begin
                res_d   = 1'b0;
                state_d = ST_RESULT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEARCH: begin
        step = 1'b1;
        if (status.done) begin
          res_d   = status.hit;
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign req_i.ready     = (state_q == ST_IDLE);
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.connected = out_data_q;

endmodule

@@ rtl/gr_checker.sv @@
// ----------------------------------------------------------------------------
// Graph reachability port checker
// Concurrent assertions on the top level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "graph_reachability_query_top_macros.svh"

module gr_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      req_valid_i,
  input logic                      req_ready_i,
  input logic [gr_pkg::KIND_W-1:0] req_kind_i,
  input logic                      rsp_valid_i,
  input logic                      rsp_ready_i,
  input logic                      rsp_connected_i
);
  import gr_pkg::*;

  logic req_fire;
  logic is_query;

  assign req_fire = req_valid_i && req_ready_i;
  assign is_query = (req_kind_i == KIND_QUERY);

  `GRQ_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i,
                   rsp_valid_i && $stable(rsp_connected_i))
  `GRQ_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, req_fire && is_query, !req_ready_i)
  `GRQ_ASSERT_NEXT(a_update_ready, clk_i, rst_ni, req_fire && !is_query, req_ready_i)
  `GRQ_ASSERT_SAME(a_rsp_from_search, clk_i, rst_ni, $rose(rsp_valid_i), !$past(req_ready_i))

endmodule

bind graph_reachability_query_top gr_checker u_gr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .req_kind_i      (req_i.kind),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_connected_i (rsp_o.connected)
);

@@ tb/sv/tb_graph_reachability_query_top.sv @@
// ----------------------------------------------------------------------------
// Graph reachability query testbench
// Drives add, clear, query and unused transactions into the block and keeps
// its own copy of the adjacency matrix. Each query is answered by a breadth
// walk over that copy, and every response is checked against the oldest
// outstanding answer. Both channels idle at random between transactions.
// ----------------------------------------------------------------------------
module tb_graph_reachability_query_top;
  import gr_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int IDLE_MAX     = 13;
  localparam int FIELD_MAX    = (1 << FIELD_W) - 1;
  localparam int DRAIN_CYCLES = NODE_COUNT + 4;

  logic clk;
  logic rst_n;
  int   req_gap_max    = IDLE_MAX;
  int   rsp_gap_max    = IDLE_MAX;
  int   mismatch_count = 0;
  row_t model_rows [NODE_COUNT];
  logic pending_connected [$];

  gr_req_if req_if ();
  gr_rsp_if rsp_if ();

  graph_reachability_query_top u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(string what, logic expected, logic actual);
    mismatch_count++;
    $display("mismatch: %s expected %b got %b at %0t", what, expected, actual, $time);
  endtask

  function automatic logic node_exists(field_t n);
    return int'(n) < NODE_COUNT;
  endfunction

  function automatic logic reach_flag(field_t src, field_t dst);
    row_t seen;
    row_t grown;
    if (!(node_exists(src) && node_exists(dst))) return 1'b0;
    seen      = '0;
    seen[src] = 1'b1;
    for (int step = 0; step < NODE_COUNT; step++) begin
      grown = seen;
      for (int i = 0; i < NODE_COUNT; i++) begin
        if (seen[i]) grown |= model_rows[i];
      end
      if (grown == seen) break;
      seen = grown;
    end
    return seen[dst];
  endfunction

  function automatic void predict_request(logic [KIND_W-1:0] kind, field_t src, field_t dst);
    if (kind == KIND_ADD) begin
      if (node_exists(src) && node_exists(dst)) model_rows[src][dst] = 1'b1;
    end else if (kind == KIND_CLEAR) begin
      foreach (model_rows[i]) model_rows[i] = '0;
    end else if (kind == KIND_QUERY) begin
      pending_connected = {pending_connected, reach_flag(src, dst)};
    end
  endfunction

  task automatic send_request(logic [KIND_W-1:0] kind, field_t src, field_t dst);
    int gap;
    gap = $urandom_range(req_gap_max, 0);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.kind        <= kind;
    req_if.source_node <= src;
    req_if.target_node <= dst;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    predict_request(kind, src, dst);
  endtask

  function automatic field_t random_field();
    return field_t'($urandom);
  endfunction

  function automatic field_t pick_node(int base, int span);
    return field_t'(base + $urandom_range(span - 1, 0));
  endfunction

  task automatic run_episode(int items);
    int base;
    int span;
    int roll;
    base = $urandom_range(FIELD_MAX, 0);
    span = $urandom_range(FIELD_MAX + 1, 2);
    send_request(KIND_CLEAR, random_field(), random_field());
    repeat (items) begin
      roll = $urandom_range(99, 0);
      if (roll < 50) begin
        send_request(KIND_ADD, pick_node(base, span), pick_node(base, span));
      end else if (roll < 92) begin
        send_request(KIND_QUERY, pick_node(base, span), pick_node(base, span));
      end else if (roll < 97) begin
        send_request(KIND_UNUSED, random_field(), random_field());
      end else begin
        send_request(KIND_CLEAR, random_field(), random_field());
      end
    end
  endtask

  task automatic test_directed_cases();
    req_gap_max = IDLE_MAX;
    rsp_gap_max = IDLE_MAX;
    send_request(KIND_QUERY,  5'd0,  5'd0);
    send_request(KIND_QUERY,  5'd31, 5'd31);
    send_request(KIND_QUERY,  5'd0,  5'd31);
    send_request(KIND_ADD,    5'd0,  5'd31);
    send_request(KIND_QUERY,  5'd0,  5'd31);
    send_request(KIND_QUERY,  5'd31, 5'd0);
    send_request(KIND_ADD,    5'd31, 5'd0);
    send_request(KIND_QUERY,  5'd31, 5'd0);
    send_request(KIND_QUERY,  5'd31, 5'd31);
    send_request(KIND_UNUSED, 5'd5,  5'd6);
    send_request(KIND_QUERY,  5'd5,  5'd6);
    send_request(KIND_ADD,    5'd10, 5'd10);
    send_request(KIND_QUERY,  5'd10, 5'd11);
    send_request(KIND_ADD,    5'd10, 5'd11);
    send_request(KIND_ADD,    5'd11, 5'd12);
    send_request(KIND_QUERY,  5'd10, 5'd12);
    send_request(KIND_QUERY,  5'd12, 5'd10);
    send_request(KIND_CLEAR,  5'd0,  5'd0);
    send_request(KIND_QUERY,  5'd0,  5'd31);
    send_request(KIND_QUERY,  5'd10, 5'd12);
    send_request(KIND_QUERY,  5'd21, 5'd10);
    send_request(KIND_ADD,    5'd21, 5'd10);
    send_request(KIND_QUERY,  5'd21, 5'd10);
    send_request(KIND_CLEAR,  5'd31, 5'd31);
    send_request(KIND_QUERY,  5'd21, 5'd21);
  endtask

  task automatic test_random_graphs();
    req_gap_max = IDLE_MAX;
    rsp_gap_max = IDLE_MAX;
    repeat (60) run_episode($urandom_range(24, 12));
  endtask

  task automatic test_long_chains();
    field_t order [NODE_COUNT];
    field_t swap;
    int     j;
    req_gap_max = IDLE_MAX;
    rsp_gap_max = IDLE_MAX;
    repeat (3) begin
      foreach (order[i]) order[i] = field_t'(i);
      for (int i = NODE_COUNT - 1; i > 0; i--) begin
        j        = $urandom_range(i, 0);
        swap     = order[i];
        order[i] = order[j];
        order[j] = swap;
      end
      send_request(KIND_CLEAR, random_field(), random_field());
      for (int i = 0; i < NODE_COUNT - 1; i++) begin
        send_request(KIND_ADD, order[i], order[i + 1]);
      end
      send_request(KIND_QUERY, order[0], order[NODE_COUNT - 1]);
      send_request(KIND_QUERY, order[NODE_COUNT - 1], order[0]);
      if ($urandom_range(1, 0) == 1) begin
        send_request(KIND_ADD, order[NODE_COUNT - 1], order[0]);
      end
      repeat (6) begin
        send_request(KIND_QUERY, order[$urandom_range(NODE_COUNT - 1, 0)],
                     order[$urandom_range(NODE_COUNT - 1, 0)]);
      end
    end
  endtask

  task automatic test_back_to_back();
    req_gap_max = 0;
    rsp_gap_max = 0;
    repeat (10) run_episode($urandom_range(24, 12));
    req_gap_max = IDLE_MAX;
    rsp_gap_max = IDLE_MAX;
  endtask

  always @(posedge clk) begin : check_responses
    logic expected_flag;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_connected.size() == 0) begin
        report_mismatch("response with no query outstanding", 1'bx, rsp_if.connected);
      end else begin
        expected_flag = pending_connected.pop_front();
        if (rsp_if.connected !== expected_flag) begin
          report_mismatch("connected", expected_flag, rsp_if.connected);
        end
      end
    end
  end

  initial begin : drive_response_ready
    int stall;
    rsp_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = $urandom_range(rsp_gap_max, 0);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_if.valid) @(posedge clk);
    end
  end

  initial begin
    foreach (model_rows[i]) model_rows[i] = '0;
    req_if.valid       <= 1'b0;
    req_if.kind        <= KIND_ADD;
    req_if.source_node <= '0;
    req_if.target_node <= '0;
    rst_n              <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_graphs();
    test_long_chains();
    test_back_to_back();
    req_if.valid <= 1'b0;
    while (pending_connected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/gr_pkg.sv
rtl/gr_if.sv
rtl/gr_adj_store.sv
rtl/gr_bfs.sv
rtl/graph_reachability_query_top.sv
rtl/gr_checker.sv
tb/sv/tb_graph_reachability_query_top.sv
